@@ design/weighted_line_fit_accumulator_assert.svh @@
// Assertion macros shared by the line-fit checker.
`ifndef WEIGHTED_LINE_FIT_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_LINE_FIT_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication.
`define WLFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WLFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/wlfa_pkg.sv @@
// Shared types, constants and helper functions of the line-fit accumulator.
package wlfa_pkg;

   localparam logic [1:0] OP_CLEAR        = 2'd0;
   localparam logic [1:0] OP_ADD          = 2'd1;
   localparam logic [1:0] OP_ADD_IMPLICIT = 2'd2;
   localparam logic [1:0] OP_REPORT       = 2'd3;

   localparam logic [7:0]  DIV_STEPS_INT  = 8'd128;
   localparam logic [7:0]  DIV_STEPS_FRAC = 8'd144;
   localparam logic [2:0]  MUL_LAST       = 3'd4;
   localparam logic [4:0]  SQRT_LAST      = 5'd31;
   localparam logic [63:0] SQRT_TOP       = 64'h4000_0000_0000_0000;
   localparam logic [32:0] IMPLICIT_LIMIT = 33'd32767;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic [15:0]        sample_weight;
   } wlfa_req_type;

   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
      logic signed [31:0] mid_range_value;
      logic [31:0]        peak_residual;
      logic [31:0]        rms_residual;
      logic [31:0]        sample_count;
      logic               flat_fit;
      logic               no_weight;
   } wlfa_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ACCUM,
      ST_WX, ST_WY, ST_XX, ST_WXX, ST_XY, ST_WXY,
      ST_D1, ST_D2, ST_N1, ST_N2, ST_SLOPE, ST_ICM, ST_ICD,
      ST_RES, ST_SQ, ST_TERM, ST_RMSD, ST_SQRT, ST_MIDM, ST_DONE
   } wlfa_state_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sat_add64 = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
         sat_add64 = s[63:0];
      end
   endfunction

   function automatic logic signed [31:0] div_clamp(input logic [63:0] q, input logic neg);
      if (neg) begin
         if (q >= 64'h8000_0000) begin
            div_clamp = 32'sh8000_0000;
         end else begin
            div_clamp = $signed(32'd0 - q[31:0]);
         end
      end else begin
         if (q > 64'h7FFF_FFFF) begin
            div_clamp = 32'sh7FFF_FFFF;
         end else begin
            div_clamp = $signed(q[31:0]);
         end
      end
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) begin
         clamp32 = 32'sh7FFF_FFFF;
      end else if (v < -64'sh8000_0000) begin
         clamp32 = 32'sh8000_0000;
      end else begin
         clamp32 = v[31:0];
      end
   endfunction

endpackage

@@ design/wlfa_mul.sv @@
// Sequential signed 64x64 multiplier built from four 32x32 partial products.
module wlfa_mul import wlfa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  a,
   input  logic signed [63:0]  b,
   output logic                done,
   output logic signed [127:0] prod
);

   logic         busy_ff;
   logic         done_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  ma_ff;
   logic [63:0]  mb_ff;
   logic         neg_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   sh_ff;
   logic         pv_ff;
   logic [127:0] acc_ff;

   logic [63:0]  a_mag;
   logic [63:0]  b_mag;
   logic [31:0]  ha;
   logic [31:0]  hb;
   logic [63:0]  pp_now;
   logic [127:0] pp_wide;

   assign a_mag   = a[63] ? 64'(-a) : a;
   assign b_mag   = b[63] ? 64'(-b) : b;
   assign ha      = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign hb      = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign pp_now  = ha * hb;
   assign pp_wide = {64'd0, pp_ff} << {sh_ff, 5'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == MUL_LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= a_mag;
         mb_ff  <= b_mag;
         neg_ff <= a[63] ^ b[63];
         acc_ff <= '0;
         cnt_ff <= '0;
         pv_ff  <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 3'd1;
         pv_ff  <= (cnt_ff != MUL_LAST);
         pp_ff  <= pp_now;
         sh_ff  <= {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
         if (pv_ff) begin
            acc_ff <= acc_ff + pp_wide;
         end
      end
   end

   assign done = done_ff;
   assign prod = neg_ff ? $signed(128'd0 - acc_ff) : $signed(acc_ff);

endmodule

@@ design/wlfa_div.sv @@
// Restoring divider, one quotient bit a cycle, quotient saturating at 64 bits.
module wlfa_div import wlfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] dividend,
   input  logic [127:0] divisor,
   input  logic         frac_mode,
   output logic         done,
   output logic [63:0]  quotient
);

   logic         busy_ff;
   logic         done_ff;
   logic [7:0]   cnt_ff;
   logic [127:0] dd_ff;
   logic [127:0] rem_ff;
   logic [127:0] dv_ff;
   logic [63:0]  q_ff;
   logic         sat_ff;

   logic [128:0] rem_sh;
   logic [128:0] rem_diff;
   logic         take;

   assign rem_sh   = {rem_ff, dd_ff[127]};
   assign rem_diff = rem_sh - {1'b0, dv_ff};
   assign take     = rem_sh >= {1'b0, dv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 8'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= frac_mode ? DIV_STEPS_FRAC : DIV_STEPS_INT;
         dd_ff  <= dividend;
         dv_ff  <= divisor;
         rem_ff <= '0;
         q_ff   <= '0;
         sat_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 8'd1;
         dd_ff  <= {dd_ff[126:0], 1'b0};
         sat_ff <= sat_ff | q_ff[63];
         q_ff   <= {q_ff[62:0], take};
         rem_ff <= take ? rem_diff[127:0] : rem_sh[127:0];
      end
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? '1 : q_ff;

endmodule

@@ design/weighted_line_fit_accumulator.sv @@
// Weighted least-squares line fit accumulator, top level.
// One request is taken at a time; req_ready is high only while the block is
// idle. An add request computes 15 products on the shared 64x64 multiplier,
// up to three passes of the bit-serial divider (Q16.16 quotients for the slope
// and rms, and one for the intercept) and a square root. Clear and report
// requests skip the sample products and the residual; every request skips
// the divisions that an empty or flat fit does not need. A finished response
// waits in an output register, so a new request can be taken while it is
// pending.
module weighted_line_fit_accumulator import wlfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  wlfa_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output wlfa_rsp_type rsp_data
);

   wlfa_state_type state_ff, state_in;

   logic               wait_ff;
   logic               rsp_valid_ff;
   wlfa_rsp_type       rsp_ff;

   logic [47:0]        wt_ff;
   logic signed [63:0] sx_ff, sy_ff, sxx_ff, sxy_ff;
   logic [63:0]        rss_ff;
   logic [31:0]        peak_ff;
   logic signed [31:0] xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   logic [31:0]        count_ff;

   logic [1:0]          op_ff;
   logic signed [31:0]  x_ff, y_ff;
   logic [15:0]         w_ff;
   logic signed [63:0]  tmp_ff;
   logic signed [127:0] t1_ff, num_ff, den_ff;
   logic signed [31:0]  sl_ff, ic_ff, mid_ff;
   logic [31:0]         mag_ff, rms_ff;
   logic [63:0]         sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [4:0]          sq_cnt_ff;

   logic                mul_start, mul_done;
   logic signed [63:0]  mul_a, mul_b;
   logic signed [127:0] mul_prod, prod_sh16;
   logic                div_start, div_done, div_frac, div_neg;
   logic [127:0]        div_a, div_b;
   logic [63:0]         div_q;

   logic                is_add, flat, nw, accept;
   wlfa_state_type      after_slope, after_ic, rms_stage;
   logic [127:0]        num_abs, den_abs;
   logic [32:0]         next_x;
   logic signed [31:0]  implicit_x;
   logic [48:0]         wt_sum;
   logic signed [63:0]  err;
   logic [63:0]         err_mag;
   logic [31:0]         mag_now;
   logic [64:0]         rss_sum;
   logic signed [32:0]  mid_sum;
   logic signed [31:0]  mid0;
   logic [64:0]         sq_try;
   logic                sq_ge;
   logic [63:0]         sq_v_next, sq_res_next;

   wlfa_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start), .a (mul_a), .b (mul_b),
      .done (mul_done), .prod (mul_prod)
   );

   wlfa_div u_div (
      .clock (clock), .reset (reset), .start (div_start), .dividend (div_a),
      .divisor (div_b), .frac_mode (div_frac), .done (div_done), .quotient (div_q)
   );

   assign accept     = req_valid && req_ready;
   assign is_add     = (op_ff == OP_ADD) || (op_ff == OP_ADD_IMPLICIT);
   assign flat       = (den_ff == '0);
   assign nw         = (wt_ff == '0);
   assign prod_sh16  = mul_prod >>> 16;
   assign num_abs    = num_ff[127] ? 128'(-num_ff) : num_ff;
   assign den_abs    = den_ff[127] ? 128'(-den_ff) : den_ff;
   assign next_x     = {1'b0, count_ff} + 33'd1;
   assign implicit_x = (next_x > IMPLICIT_LIMIT) ? 32'sh7FFF_FFFF : {next_x[15:0], 16'd0};
   assign wt_sum     = {1'b0, wt_ff} + {33'd0, w_ff};
   assign err        = {{32{y_ff[31]}}, y_ff} - (prod_sh16[63:0] + {{32{ic_ff[31]}}, ic_ff});
   assign err_mag    = err[63] ? 64'(-err) : err;
   assign mag_now    = (err_mag[63:32] != '0) ? 32'hFFFF_FFFF : err_mag[31:0];
   assign rss_sum    = {1'b0, rss_ff} + {1'b0, mul_prod[63:0]};
   assign mid_sum    = {xmin_ff[31], xmin_ff} + {xmax_ff[31], xmax_ff};
   assign mid0       = mid_sum[32:1];
   assign sq_try     = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
   assign sq_ge      = {1'b0, sq_v_ff} >= sq_try;
   assign sq_v_next  = sq_ge ? sq_v_ff - sq_try[63:0] : sq_v_ff;
   assign sq_res_next = sq_ge ? (sq_res_ff >> 1) + sq_bit_ff : sq_res_ff >> 1;

   assign rms_stage   = nw ? ST_MIDM : ST_RMSD;
   assign after_ic    = is_add ? ST_RES : rms_stage;
   assign after_slope = nw ? after_ic : ST_ICM;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.op == OP_ADD || req_data.op == OP_ADD_IMPLICIT)
                          ? ST_ACCUM : ST_D1;
            end
         end
         ST_ACCUM: state_in = ST_WX;
         ST_WX:    if (mul_done) state_in = ST_WY;
         ST_WY:    if (mul_done) state_in = ST_XX;
         ST_XX:    if (mul_done) state_in = ST_WXX;
         ST_WXX:   if (mul_done) state_in = ST_XY;
         ST_XY:    if (mul_done) state_in = ST_WXY;
         ST_WXY:   if (mul_done) state_in = ST_D1;
         ST_D1:    if (mul_done) state_in = ST_D2;
         ST_D2:    if (mul_done) state_in = ST_N1;
         ST_N1:    if (mul_done) state_in = ST_N2;
         ST_N2:    if (mul_done) state_in = flat ? after_slope : ST_SLOPE;
         ST_SLOPE: if (div_done) state_in = after_slope;
         ST_ICM:   if (mul_done) state_in = ST_ICD;
         ST_ICD:   if (div_done) state_in = after_ic;
         ST_RES:   if (mul_done) state_in = ST_SQ;
         ST_SQ:    if (mul_done) state_in = ST_TERM;
         ST_TERM:  if (mul_done) state_in = rms_stage;
         ST_RMSD:  if (div_done) state_in = ST_SQRT;
         ST_SQRT:  if (sq_cnt_ff == SQRT_LAST) state_in = ST_MIDM;
         ST_MIDM:  if (mul_done) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mul_a     = '0;
      mul_b     = '0;
      mul_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      div_frac  = 1'b0;
      div_neg   = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_WX:  begin mul_a = {48'd0, w_ff}; mul_b = {{32{x_ff[31]}}, x_ff}; end
         ST_WY:  begin mul_a = {48'd0, w_ff}; mul_b = {{32{y_ff[31]}}, y_ff}; end
         ST_XX:  begin mul_a = {{32{x_ff[31]}}, x_ff}; mul_b = {{32{x_ff[31]}}, x_ff}; end
         ST_WXX: begin mul_a = {48'd0, w_ff}; mul_b = tmp_ff; end
         ST_XY:  begin mul_a = {{32{x_ff[31]}}, x_ff}; mul_b = {{32{y_ff[31]}}, y_ff}; end
         ST_WXY: begin mul_a = {48'd0, w_ff}; mul_b = tmp_ff; end
         ST_D1:  begin mul_a = {16'd0, wt_ff}; mul_b = sxx_ff; end
         ST_D2:  begin mul_a = sx_ff; mul_b = sx_ff; end
         ST_N1:  begin mul_a = {16'd0, wt_ff}; mul_b = sxy_ff; end
         ST_N2:  begin mul_a = sx_ff; mul_b = sy_ff; end
         ST_ICM: begin mul_a = {{32{sl_ff[31]}}, sl_ff}; mul_b = sx_ff; end
         ST_RES: begin mul_a = {{32{sl_ff[31]}}, sl_ff}; mul_b = {{32{x_ff[31]}}, x_ff}; end
         ST_SQ:  begin mul_a = {32'd0, mag_ff}; mul_b = {32'd0, mag_ff}; end
         ST_TERM: begin mul_a = tmp_ff; mul_b = {48'd0, w_ff}; end
         ST_MIDM: begin mul_a = {{32{sl_ff[31]}}, sl_ff}; mul_b = {{32{mid0[31]}}, mid0}; end
         ST_SLOPE: begin
            div_a    = num_abs;
            div_b    = den_abs;
            div_frac = 1'b1;
            div_neg  = num_ff[127] ^ den_ff[127];
         end
         ST_ICD: begin
            div_a   = num_abs;
            div_b   = {64'd0, wt_ff, 16'd0};
            div_neg = num_ff[127];
         end
         ST_RMSD: begin
            div_a    = {64'd0, rss_ff};
            div_b    = {80'd0, wt_ff};
            div_frac = 1'b1;
         end
         default: begin
         end
      endcase
      case (state_ff)
         ST_WX, ST_WY, ST_XX, ST_WXX, ST_XY, ST_WXY, ST_D1, ST_D2, ST_N1, ST_N2,
         ST_ICM, ST_RES, ST_SQ, ST_TERM, ST_MIDM: mul_start = !wait_ff;
         ST_SLOPE, ST_ICD, ST_RMSD: div_start = !wait_ff;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wt_ff        <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
         rss_ff       <= '0;
         peak_ff      <= '0;
         xmin_ff      <= '0;
         xmax_ff      <= '0;
         ymin_ff      <= '0;
         ymax_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (mul_start || div_start) begin
            wait_ff <= 1'b1;
         end else if (mul_done || div_done) begin
            wait_ff <= 1'b0;
         end
         if (state_ff == ST_DONE && state_in == ST_IDLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && req_data.op == OP_CLEAR) begin
            wt_ff    <= '0;
            sx_ff    <= '0;
            sy_ff    <= '0;
            sxx_ff   <= '0;
            sxy_ff   <= '0;
            rss_ff   <= '0;
            peak_ff  <= '0;
            xmin_ff  <= '0;
            xmax_ff  <= '0;
            ymin_ff  <= '0;
            ymax_ff  <= '0;
            count_ff <= '0;
         end
         if (state_ff == ST_ACCUM) begin
            if (count_ff == '0) begin
               xmin_ff <= x_ff;
               xmax_ff <= x_ff;
               ymin_ff <= y_ff;
               ymax_ff <= y_ff;
            end else begin
               if (x_ff < xmin_ff) xmin_ff <= x_ff;
               if (x_ff > xmax_ff) xmax_ff <= x_ff;
               if (y_ff < ymin_ff) ymin_ff <= y_ff;
               if (y_ff > ymax_ff) ymax_ff <= y_ff;
            end
            if (count_ff != '1) begin
               count_ff <= count_ff + 32'd1;
            end
            wt_ff <= wt_sum[48] ? '1 : wt_sum[47:0];
         end
         if (mul_done) begin
            case (state_ff)
               ST_WX:  sx_ff  <= sat_add64(sx_ff, mul_prod[63:0]);
               ST_WY:  sy_ff  <= sat_add64(sy_ff, mul_prod[63:0]);
               ST_WXX: sxx_ff <= sat_add64(sxx_ff, mul_prod[63:0]);
               ST_WXY: sxy_ff <= sat_add64(sxy_ff, mul_prod[63:0]);
               ST_TERM: begin
                  rss_ff <= rss_sum[64] ? '1 : rss_sum[63:0];
                  if (mag_ff > peak_ff) peak_ff <= mag_ff;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_data.op;
         x_ff   <= (req_data.op == OP_ADD_IMPLICIT) ? implicit_x : req_data.x_value;
         y_ff   <= req_data.y_value;
         w_ff   <= req_data.sample_weight;
         sl_ff  <= '0;
         ic_ff  <= '0;
         rms_ff <= '0;
      end
      if (mul_done) begin
         case (state_ff)
            ST_XX, ST_XY, ST_SQ: tmp_ff <= prod_sh16[63:0];
            ST_D1, ST_N1: t1_ff <= mul_prod;
            ST_D2:   den_ff <= t1_ff - prod_sh16;
            ST_N2:   num_ff <= t1_ff - prod_sh16;
            ST_ICM:  num_ff <= $signed({{48{sy_ff[63]}}, sy_ff, 16'd0}) - mul_prod;
            ST_RES:  mag_ff <= mag_now;
            ST_MIDM: mid_ff <= clamp32(prod_sh16[63:0] + {{32{ic_ff[31]}}, ic_ff});
            default: begin
            end
         endcase
      end
      if (div_done) begin
         case (state_ff)
            ST_SLOPE: sl_ff <= div_clamp(div_q, div_neg);
            ST_ICD:   ic_ff <= div_clamp(div_q, div_neg);
            ST_RMSD: begin
               sq_v_ff   <= div_q;
               sq_res_ff <= '0;
               sq_bit_ff <= SQRT_TOP;
               sq_cnt_ff <= '0;
            end
            default: begin
            end
         endcase
      end
      if (state_ff == ST_SQRT) begin
         sq_v_ff   <= sq_v_next;
         sq_res_ff <= sq_res_next;
         sq_bit_ff <= sq_bit_ff >> 2;
         sq_cnt_ff <= sq_cnt_ff + 5'd1;
         if (sq_cnt_ff == SQRT_LAST) begin
            rms_ff <= sq_res_next[31:0];
         end
      end
      if (state_ff == ST_DONE && state_in == ST_IDLE) begin
         rsp_ff.slope           <= sl_ff;
         rsp_ff.intercept       <= ic_ff;
         rsp_ff.mid_range_value <= mid_ff;
         rsp_ff.peak_residual   <= peak_ff;
         rsp_ff.rms_residual    <= rms_ff;
         rsp_ff.sample_count    <= count_ff;
         rsp_ff.flat_fit        <= flat;
         rsp_ff.no_weight       <= nw;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/wlfa_checker.sv @@
// Port-level checker for the line-fit accumulator and its bind.
`include "weighted_line_fit_accumulator_assert.svh"

module wlfa_port_checker import wlfa_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input wlfa_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input wlfa_rsp_type rsp_data
);

   `WLFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")
   `WLFA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while a request is in work")
   `WLFA_ASSERT_NOW(a_flat_slope, clock, reset, rsp_valid && rsp_data.flat_fit, rsp_data.slope == 32'sd0, "flat fit with nonzero slope")
   `WLFA_ASSERT_NOW(a_empty_fit, clock, reset, rsp_valid && rsp_data.no_weight, rsp_data.intercept == 32'sd0 && rsp_data.rms_residual == 32'd0, "empty fit with nonzero intercept or rms")
   `WLFA_ASSERT_NOW(a_no_samples, clock, reset, rsp_valid && rsp_data.sample_count == 32'd0, rsp_data.no_weight && rsp_data.peak_residual == 32'd0, "no samples but weight or residual present")

endmodule

bind weighted_line_fit_accumulator wlfa_port_checker u_wlfa_port_checker (.*);

@@ tb/sv/wlfa_checker.sv @@
`timescale 1ns / 1ps
// Line-fit checker: predicts each response from the accepted requests and compares.
module wlfa_checker import wlfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  wlfa_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  wlfa_rsp_type rsp_data,
   output int           fail_count,
   output int           pending
);

   localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

   longint unsigned wt, rss;
   longint          sx, sy, sxx, sxy, xmin, xmax, ymin, ymax;
   logic [31:0]     peak, cnt;
   wlfa_rsp_type    fit_queue[$];

   function automatic longint sum_sat(longint a, longint b);
      if (b > 0 && a > S64_MAX - b) return S64_MAX;
      if (b < 0 && a < S64_MIN - b) return S64_MIN;
      return a + b;
   endfunction

   function automatic logic [63:0] quot_sat(logic [127:0] a, logic [127:0] b, int frac);
      logic [159:0] q;
      q = ({32'b0, a} << frac) / {32'b0, b};
      return (q[159:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
   endfunction

   function automatic logic signed [31:0] div_q16(logic signed [127:0] n,
                                                  logic signed [127:0] d, int frac);
      logic [127:0] an, ad;
      logic [63:0]  q;
      an = n[127] ? -n : n;
      ad = d[127] ? -d : d;
      q  = quot_sat(an, ad, frac);
      if (n[127] != d[127]) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
      return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
   endfunction

   function automatic logic [31:0] root_floor(logic [63:0] v);
      logic [31:0] r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (32'd1 << b);
         if ({32'b0, t} * {32'b0, t} <= v) r = t;
      end
      return r;
   endfunction

   function automatic void clear_sums();
      wt = 0; rss = 0; sx = 0; sy = 0; sxx = 0; sxy = 0;
      xmin = 0; xmax = 0; ymin = 0; ymax = 0; peak = 0; cnt = 0;
   endfunction

   function automatic wlfa_rsp_type fit_sample(wlfa_req_type r);
      wlfa_rsp_type       o;
      longint             x, y, w, nx, err, mid, xs;
      longint unsigned    mag, term;
      logic signed [127:0] wt_w, den, num, n2, d2;
      logic signed [31:0] sl, ic;
      logic               flat, nw;
      x = r.x_value;
      y = r.y_value;
      w = r.sample_weight;
      if (r.op == OP_CLEAR) clear_sums();
      if (r.op == OP_ADD || r.op == OP_ADD_IMPLICIT) begin
         if (r.op == OP_ADD_IMPLICIT) begin
            nx = longint'({32'b0, cnt}) + 1;
            x = (nx > 32767) ? 64'sh7FFF_FFFF : (nx << 16);
         end
         if (cnt == 0) begin
            xmin = x; xmax = x; ymin = y; ymax = y;
         end else begin
            if (x < xmin) xmin = x;
            if (x > xmax) xmax = x;
            if (y < ymin) ymin = y;
            if (y > ymax) ymax = y;
         end
         if (cnt != 32'hFFFF_FFFF) cnt++;
         wt = wt + longint'(w);
         if (wt > 64'hFFFF_FFFF_FFFF) wt = 64'hFFFF_FFFF_FFFF;
         sx  = sum_sat(sx, w * x);
         sy  = sum_sat(sy, w * y);
         sxx = sum_sat(sxx, w * ((x * x) >>> 16));
         sxy = sum_sat(sxy, w * ((x * y) >>> 16));
      end
      wt_w = $signed({64'b0, wt});
      den  = wt_w * 128'(sxx) - ((128'(sx) * 128'(sx)) >>> 16);
      num  = wt_w * 128'(sxy) - ((128'(sx) * 128'(sy)) >>> 16);
      flat = (den == 0);
      sl   = flat ? 32'sd0 : div_q16(num, den, 16);
      nw   = (wt == 0);
      if (nw) begin
         ic = 0;
      end else begin
         n2 = (128'(sy) <<< 16) - 128'(longint'(sl)) * 128'(sx);
         d2 = $signed({64'b0, wt << 16});
         ic = div_q16(n2, d2, 0);
      end
      if (r.op == OP_ADD || r.op == OP_ADD_IMPLICIT) begin
         err = y - (((longint'(sl) * x) >>> 16) + longint'(ic));
         mag = (err < 0) ? -err : err;
         if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
         term = ((mag * mag) >> 16) * longint'(w);
         rss = (rss > ~64'd0 - term) ? ~64'd0 : rss + term;
         if (mag > peak) peak = mag[31:0];
      end
      o.rms_residual = nw ? 32'd0 : root_floor(quot_sat({64'b0, rss}, {64'b0, wt}, 16));
      xs  = (xmin + xmax) >>> 1;
      mid = ((longint'(sl) * xs) >>> 16) + longint'(ic);
      o.slope           = sl;
      o.intercept       = ic;
      o.mid_range_value = (mid > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                          (mid < -64'sh8000_0000) ? 32'sh8000_0000 : mid[31:0];
      o.peak_residual   = peak;
      o.sample_count    = cnt;
      o.flat_fit        = flat;
      o.no_weight       = nw;
      return o;
   endfunction

   assign pending = fit_queue.size();

   initial begin
      fail_count = 0;
      clear_sums();
   end

   always @(posedge clock) begin
      wlfa_rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (fit_queue.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               fail_count++;
            end else begin
               e = fit_queue.pop_front();
               if (rsp_data.slope !== e.slope)
                  $display("%0t: slope exp %h got %h", $time, e.slope, rsp_data.slope);
               if (rsp_data.intercept !== e.intercept)
                  $display("%0t: intercept exp %h got %h", $time, e.intercept,
                           rsp_data.intercept);
               if (rsp_data.mid_range_value !== e.mid_range_value)
                  $display("%0t: mid_range_value exp %h got %h", $time,
                           e.mid_range_value, rsp_data.mid_range_value);
               if (rsp_data.peak_residual !== e.peak_residual)
                  $display("%0t: peak_residual exp %h got %h", $time, e.peak_residual,
                           rsp_data.peak_residual);
               if (rsp_data.rms_residual !== e.rms_residual)
                  $display("%0t: rms_residual exp %h got %h", $time, e.rms_residual,
                           rsp_data.rms_residual);
               if (rsp_data.sample_count !== e.sample_count)
                  $display("%0t: sample_count exp %h got %h", $time, e.sample_count,
                           rsp_data.sample_count);
               if (rsp_data.flat_fit !== e.flat_fit)
                  $display("%0t: flat_fit exp %b got %b", $time, e.flat_fit,
                           rsp_data.flat_fit);
               if (rsp_data.no_weight !== e.no_weight)
                  $display("%0t: no_weight exp %b got %b", $time, e.no_weight,
                           rsp_data.no_weight);
               if (rsp_data !== e) fail_count++;
            end
         end
         if (req_valid && req_ready) fit_queue.push_back(fit_sample(req_data));
      end
   end

endmodule

@@ tb/sv/tb_weighted_line_fit_accumulator.sv @@
`timescale 1ns / 1ps
// Testbench top: request stimulus, response back-pressure and the verdict.
module tb_weighted_line_fit_accumulator;
   import wlfa_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_ready;
   wlfa_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 0;
   wlfa_rsp_type rsp_data;
   int           fail_count, pending;
   bit           hold_rsp = 0;

   weighted_line_fit_accumulator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   wlfa_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   always #10 clock = ~clock;

   task automatic send(logic [1:0] op, logic [31:0] x, logic [31:0] y, logic [15:0] w);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= '{op: op, x_value: x, y_value: y, sample_weight: w};
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
         5: return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
         6, 7: return $urandom;
         8: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(0, 7))
         0, 1, 2: return 16'd256;
         3: return $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
         4: return 16'($urandom);
         default: return 16'($urandom_range(1, 1024));
      endcase
   endfunction

   always begin
      int gap, span;
      @(posedge clock);
      if (!reset) begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            span = 3000;
            while (span > 0) begin
               @(posedge clock);
               span--;
            end
            hold_rsp = 0;
         end
         gap = $urandom_range(0, 3);
         if ($urandom_range(0, 7) == 0) gap = 0;
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int k, r;
      logic [1:0] op;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(OP_CLEAR, 0, 0, 0);
      send(OP_REPORT, 32'h1234_5678, 32'h8765_4321, 16'hFFFF);
      send(OP_ADD, 32'h0001_0000, 32'h0002_0000, 16'd0);
      send(OP_ADD, 32'h0001_0000, 32'h0003_0000, 16'd256);
      send(OP_ADD, 32'h0001_0000, 32'h0005_0000, 16'd256);
      send(OP_ADD, 32'h0003_0000, 32'hFFFF_0000, 16'd512);
      send(OP_REPORT, 0, 0, 0);
      send(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
      send(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
      send(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 16'd1);
      send(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      for (k = 0; k < 5; k++)
         send(OP_ADD_IMPLICIT, 32'hFFFF_FFFF, (k * 3 + 1) << 16, 16'd256);
      send(OP_ADD, 32'h0000_8000, 32'h0010_0000, 16'd128);
      send(OP_CLEAR, 0, 0, 0);
      send(OP_ADD_IMPLICIT, 0, 32'h8000_0000, 16'd0);
      send(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
      send(OP_ADD, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
      send(OP_REPORT, 0, 0, 0);
      for (k = 0; k < 1400; k++) begin
         if (k == 400) hold_rsp = 1;
         if (k == 800) begin
            req_valid <= 0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
         end
         r = $urandom_range(0, 99);
         op = (r < 3) ? OP_CLEAR : (r < 8) ? OP_REPORT : (r < 60) ? OP_ADD : OP_ADD_IMPLICIT;
         send(op, pick_value(), pick_value(), pick_weight());
      end
      req_valid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (700) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("weighted_line_fit_accumulator verification clean");
      end else begin
         $display("weighted_line_fit_accumulator verification failed");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("weighted_line_fit_accumulator verification failed");
      $finish;
   end

endmodule
